/* rtl/http_request_target_checker_unit_assert.svh */
// ----------------------------------------------------------------------------
// HTTP request target checker - assertion macros
// Shared concurrent assertion helpers for the checker RTL.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_TARGET_CHECKER_UNIT_ASSERT_SVH
`define HTTP_REQUEST_TARGET_CHECKER_UNIT_ASSERT_SVH

// Checked on every rising clock edge, masked while reset is applied.
`define HTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define HTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/htc_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP request target checker - package
// Character constants and the byte class type shared by the checker modules.
// ----------------------------------------------------------------------------
package htc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned OwedW  = 2;

  // Characters with a role of their own in origin form
  localparam logic [ByteW-1:0] CharPercent = 8'h25;  // '%'
  localparam logic [ByteW-1:0] CharSlash   = 8'h2F;  // '/'
  localparam logic [ByteW-1:0] CharQmark   = 8'h3F;  // '?'
  localparam logic [ByteW-1:0] CharColon   = 8'h3A;  // ':'
  localparam logic [ByteW-1:0] CharAt      = 8'h40;  // '@'

  // Hex digits that a '%' escape requires
  localparam logic [OwedW-1:0] EscapeDigits = 2'd2;

  // Classification of one target byte
  typedef struct packed {
    logic is_slash;
    logic is_percent;
    logic is_qmark;
    logic is_hex;
    logic is_plain;   // unreserved, sub-delims, ':', '@', '/'
  } byte_class_t;

endpackage

/* rtl/http_request_target_checker_unit.sv */
// ----------------------------------------------------------------------------
// HTTP request target checker
// Validates an origin-form request target streamed one byte per request.
// ----------------------------------------------------------------------------
// The block takes one target byte per clock cycle with no gaps needed between
// bytes or between targets, unless a final byte waits on a stalled result
// register; non-final bytes never wait on it and keep flowing through the check
// stage. Each byte is captured in an input register, checked against the running
// target state by the byte classifier and the update logic in the next cycle,
// and on the byte marked final the verdict lands in the result register, so the
// result of a target shows up in the cycle after its final byte is taken.
// ----------------------------------------------------------------------------
`include "http_request_target_checker_unit_assert.svh"

module http_request_target_checker_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // byte stream in
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [htc_pkg::ByteW-1:0] target_byte_i,
  input  logic                      final_byte_i,
  // verdict out
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      accepted_o
);

  // Input register
  logic                      in_valid_q;
  logic [htc_pkg::ByteW-1:0] byte_q;
  logic                      final_q;

  // Target state
  logic                      at_first_q, at_first_d;
  logic                      in_query_q, in_query_d;
  logic [htc_pkg::OwedW-1:0] owed_q, owed_d;
  logic                      failed_q, failed_d;

  // Result register
  logic                      out_valid_q;
  logic                      accepted_q, accepted_d;

  logic                      out_free;
  logic                      take;
  logic                      load;
  logic                      emit;
  htc_pkg::byte_class_t      cls;

  // Handshake: only a final byte needs room in the result register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign take       = in_valid_q && (!final_q || out_free);
  assign emit       = take && final_q;
  assign load       = !in_valid_q || take;
  assign in_stall_o = !load;

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;

  // Capture the incoming request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      byte_q  <= target_byte_i;
      final_q <= final_byte_i;
    end
  end

  htc_byte_class u_byte_class (
    .byte_i  (byte_q),
    .class_o (cls)
  );

  // Per-byte check and state update
  always_comb begin
    in_query_d = in_query_q;
    owed_d     = owed_q;
    failed_d   = failed_q;
    if (!failed_q) begin
      if (at_first_q) begin
        failed_d = !cls.is_slash;
      end else if (owed_q != '0) begin
        if (cls.is_hex) begin
          owed_d = owed_q - htc_pkg::OwedW'(1);
        end else begin
          failed_d = 1'b1;
        end
      end else if (cls.is_percent) begin
        owed_d = htc_pkg::EscapeDigits;
      end else if (cls.is_qmark) begin
        in_query_d = 1'b1;
      end else if (!cls.is_plain) begin
        failed_d = 1'b1;
      end
    end
    at_first_d = 1'b0;
    accepted_d = !failed_d && (owed_d == '0);
    // Final byte: clear for the next target
    if (final_q) begin
      at_first_d = 1'b1;
      in_query_d = 1'b0;
      owed_d     = '0;
      failed_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_first_q <= 1'b1;
      in_query_q <= 1'b0;
      owed_q     <= '0;
      failed_q   <= 1'b0;
    end else if (take) begin
      at_first_q <= at_first_d;
      in_query_q <= in_query_d;
      owed_q     <= owed_d;
      failed_q   <= failed_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      accepted_q <= accepted_d;
    end
  end

  // Assertions
  `HTC_ASSERT(a_owed_range, owed_q != 2'd3, "escape digit count out of range")
  `HTC_ASSERT_ALWAYS(a_query_after_first, in_query_q |-> !at_first_q,
                     "query flag set at the first byte of a target")
  `HTC_ASSERT(a_clear_after_final,
              emit |=> (at_first_q && !in_query_q && !failed_q && owed_q == 2'd0),
              "target state not cleared after final byte")
  `HTC_ASSERT(a_failed_sticks, (failed_q && !emit) |=> failed_q,
              "rejection dropped before the final byte")

endmodule

/* rtl/htc_byte_class.sv */
// ----------------------------------------------------------------------------
// HTTP request target checker - byte classifier
// Sorts one byte into the character sets of the origin form grammar.
// ----------------------------------------------------------------------------
module htc_byte_class (
  input  logic [htc_pkg::ByteW-1:0] byte_i,
  output htc_pkg::byte_class_t      class_o
);

  logic is_digit;
  logic is_lower;
  logic is_upper;
  logic is_mark;

  // Letters and digits
  assign is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign is_lower = (byte_i >= 8'h61) && (byte_i <= 8'h7A);
  assign is_upper = (byte_i >= 8'h41) && (byte_i <= 8'h5A);

  // Unreserved marks, sub-delims and the extra path characters
  always_comb begin
    case (byte_i)
      8'h2D, 8'h2E, 8'h5F, 8'h7E,                         // - . _ ~
      8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29,           // ! $ & ' ( )
      8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D,                  // * + , ; =
      htc_pkg::CharColon, htc_pkg::CharAt,
      htc_pkg::CharSlash: is_mark = 1'b1;
      default:            is_mark = 1'b0;
    endcase
  end

  assign class_o.is_slash   = (byte_i == htc_pkg::CharSlash);
  assign class_o.is_percent = (byte_i == htc_pkg::CharPercent);
  assign class_o.is_qmark   = (byte_i == htc_pkg::CharQmark);
  assign class_o.is_hex     = is_digit
                            || ((byte_i >= 8'h61) && (byte_i <= 8'h66))
                            || ((byte_i >= 8'h41) && (byte_i <= 8'h46));
  assign class_o.is_plain   = is_digit || is_lower || is_upper || is_mark;

endmodule
